### rtl/suffix_array_lcp_builder_macros.svh
// Assertion macros used by the checker file of the suffix array builder.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define SALCP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

// The consequent must hold in the same clock as the antecedent.
`define SALCP_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

`endif

### rtl/salcp_pkg.sv
// Package with types, codes and constants of the suffix array builder.
`default_nettype none
package salcp_pkg;

    localparam int FIELD_W = 13;
    localparam int DEF_MAX_LEN = 4096;
    localparam int DEF_ALPHABET = 26;
    localparam logic [7:0] CHAR_BASE = 8'd97;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_BUILD  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } stat_t;

    typedef struct packed {
        act_t               action;
        logic [7:0]         char_code;
        logic [FIELD_W-1:0] rank_index;
    } req_t;

    typedef struct packed {
        stat_t              status;
        logic [FIELD_W-1:0] suffix_start;
        logic [FIELD_W-1:0] lcp_prev;
        logic [FIELD_W-1:0] text_length;
    } rsp_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DEC, S_RDW, S_FIN, S_DONE,
        S_INIT_RD, S_INIT_WR,
        S_CLR, S_CNT_A, S_CNT_B, S_CNT_C, S_CNT_D,
        S_PFX_RD, S_PFX_WR, S_PL_A, S_PL_B, S_PL_C, S_PL_D,
        S_TAIL, S_SH_RD, S_SH_WR,
        S_CLS_A, S_CLS_B, S_CLS_C, S_CLS_D,
        S_INV_RD, S_INV_WR,
        S_K_A, S_K_B, S_K_C, S_K_D, S_K_E, S_K_F
    } state_t;

    typedef struct packed {
        state_t phase;
        logic   take;
    } cmd_t;

    typedef struct packed {
        act_t action;
        logic empty;
        logic req_ok;
        logic at_n;
        logic at_top;
        logic at_one;
        logic first;
        logic more;
        logic r_low;
        logic inb;
        logic eq;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### rtl/suffix_array_lcp_builder.sv
// Top level of the suffix array and LCP builder: controller plus datapath.
//
//   Channel   Direction  Payload  Handshake
//   s_        in         req_t    s_valid / s_ready
//   m_        out        rsp_t    m_valid / m_ready
//
// An append, clear or rejected request passes through the decode and finish states
// to the output register, and a read also through a wait state for the registered
// memory read; the next request is taken once the controller is back in idle.
// A build sorts the characters once, then per doubling round runs a counting sort
// and a class pass, then an LCP pass; every memory has a single read port.
// Reset is synchronous and needs no clearing pass; rank entries past the text end are
// masked to zero. A result waits in the output register while the next request is
// taken; a request finishing while that register is still full stalls until it drains.
`default_nettype none
module suffix_array_lcp_builder
    import salcp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int ALPHABET = DEF_ALPHABET
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    cmd_t cmd;
    sts_t sts;

    salcp_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .sts(sts),
        .cmd(cmd)
    );

    salcp_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .s_valid(s_valid),
        .s_data(s_data),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .m_data(m_data),
        .sts(sts)
    );

    assign s_ready = cmd.take;

endmodule
`default_nettype wire

### rtl/salcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/salcp_ctrl.sv
// Controller state machine that sequences requests and the build passes.
`default_nettype none
module salcp_ctrl
    import salcp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_t next_i;
        next_i = sts.at_n ? S_DONE : S_K_A;
        state_next = state_reg;
        cmd.phase = state_reg;
        cmd.take = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DEC;
            end
            S_DEC: begin
                case (sts.action)
                    ACT_BUILD: state_next = sts.empty ? S_DONE : S_INIT_RD;
                    ACT_READ:  state_next = sts.req_ok ? S_RDW : S_FIN;
                    default:   state_next = S_FIN;
                endcase
            end
            S_RDW:     state_next = S_FIN;
            S_DONE:    state_next = S_FIN;
            S_FIN: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            S_INIT_RD: state_next = S_INIT_WR;
            S_INIT_WR: state_next = sts.at_n ? S_CLR : S_INIT_RD;
            S_CLR: begin
                if (sts.at_top) state_next = S_CNT_A;
            end
            S_CNT_A:   state_next = S_CNT_B;
            S_CNT_B:   state_next = S_CNT_C;
            S_CNT_C:   state_next = S_CNT_D;
            S_CNT_D:   state_next = sts.at_n ? S_PFX_RD : S_CNT_A;
            S_PFX_RD:  state_next = S_PFX_WR;
            S_PFX_WR:  state_next = sts.at_top ? S_PL_A : S_PFX_RD;
            S_PL_A:    state_next = S_PL_B;
            S_PL_B:    state_next = S_PL_C;
            S_PL_C:    state_next = S_PL_D;
            S_PL_D: begin
                if (sts.at_one) begin
                    state_next = sts.first ? S_TAIL : S_CLS_A;
                end else begin
                    state_next = S_PL_A;
                end
            end
            S_TAIL: begin
                if (sts.at_n) state_next = S_SH_RD;
            end
            S_SH_RD:   state_next = S_SH_WR;
            S_SH_WR:   state_next = sts.at_n ? S_CLR : S_SH_RD;
            S_CLS_A:   state_next = S_CLS_B;
            S_CLS_B:   state_next = S_CLS_C;
            S_CLS_C:   state_next = S_CLS_D;
            S_CLS_D: begin
                if (sts.at_n) begin
                    state_next = sts.more ? S_TAIL : S_INV_RD;
                end else begin
                    state_next = S_CLS_A;
                end
            end
            S_INV_RD:  state_next = S_INV_WR;
            S_INV_WR:  state_next = sts.at_n ? S_K_A : S_INV_RD;
            S_K_A:     state_next = S_K_B;
            S_K_B:     state_next = sts.r_low ? next_i : S_K_C;
            S_K_C:     state_next = S_K_D;
            S_K_D:     state_next = sts.inb ? S_K_E : next_i;
            S_K_E:     state_next = S_K_F;
            S_K_F:     state_next = sts.eq ? S_K_D : next_i;
            default:   state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/salcp_dp.sv
// Datapath with the text, order, rank, bucket and LCP memories and counters.
`default_nettype none
module salcp_dp
    import salcp_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int ALPHABET = DEF_ALPHABET
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    input  wire logic s_valid,
    input  wire req_t s_data,
    input  wire logic m_ready,
    output logic      m_valid,
    output rsp_t      m_data,
    output sts_t      sts
);

    localparam int KMAX = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int VW = $clog2(KMAX + 1);
    localparam int CW = $clog2(ALPHABET + 1);
    localparam int CMPW = (AW > FIELD_W) ? AW : FIELD_W;

    req_t          req_reg, req_next;
    rsp_t          res_reg, res_next, mdat_reg;
    logic          mv_reg, mv_next;
    logic [AW-1:0] len_reg, len_next;
    logic          built_reg, built_next;
    logic [VW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] e_reg, e_next;
    logic [AW:0]   step_reg, step_next;
    logic          sel_reg, sel_next;
    logic          first_reg, first_next;
    logic [AW-1:0] cls_reg, cls_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [VW-1:0] key_reg, key_next;
    logic [VW-1:0] sum_reg, sum_next;
    logic [VW-1:0] va_reg, va_next, pva_reg, pva_next, pvb_reg, pvb_next;
    logic [AW-1:0] a_reg, a_next;
    logic          hi_reg, hi_next;
    logic [AW-1:0] r_reg, r_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic [CW-1:0] t1_reg, t1_next;

    logic          txt_we;
    logic [AW-1:0] txt_waddr, txt_raddr;
    logic [CW-1:0] txt_wdata, txt_rdata;
    logic          ord_we;
    logic [AW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic          lcp_we;
    logic [AW-1:0] lcp_waddr, lcp_wdata, lcp_raddr, lcp_rdata;
    logic          bkt_we;
    logic [VW-1:0] bkt_waddr, bkt_wdata, bkt_raddr, bkt_rdata;
    logic          cur_we, alt_we;
    logic [AW-1:0] cur_waddr, cur_raddr, alt_waddr, alt_raddr;
    logic [VW-1:0] cur_wdata, alt_wdata, cur_rdata, alt_rdata;
    logic          rk0_we, rk1_we;
    logic [AW-1:0] rk0_waddr, rk0_raddr, rk1_waddr, rk1_raddr;
    logic [VW-1:0] rk0_wdata, rk1_wdata, rk0_rdata, rk1_rdata;

    logic [VW-1:0] nv, top, vb_cur;
    logic [AW:0]   n1, st2, tst2, hi_sum, ip, jp;
    logic [7:0]    ch_off;
    logic          ch_ok, req_ok, out_free, more, r_low, inb, eq, diff;
    logic [AW-1:0] cls_n, rk_r;

    assign nv = VW'(len_reg);
    assign top = (nv > VW'(ALPHABET)) ? nv : VW'(ALPHABET);
    assign n1 = (AW+1)'(len_reg);
    assign st2 = step_reg << 1;
    assign tst2 = (st2 > n1) ? (AW+1)'(1) : n1 + (AW+1)'(1) - st2;
    assign hi_sum = (AW+1)'(a_reg) + step_reg;
    assign ip = (AW+1)'(cnt_reg) + (AW+1)'(k_reg);
    assign jp = (AW+1)'(j_reg) + (AW+1)'(k_reg);
    assign ch_off = req_reg.char_code - CHAR_BASE;
    assign ch_ok = (req_reg.char_code >= CHAR_BASE) && (9'(ch_off) < 9'(ALPHABET));
    assign req_ok = built_reg && (req_reg.rank_index != '0)
                    && (CMPW'(req_reg.rank_index) <= CMPW'(len_reg));
    assign out_free = !mv_reg || m_ready;
    assign vb_cur = hi_reg ? alt_rdata : '0;
    assign diff = (cnt_reg == VW'(1)) || (va_reg != pva_reg) || (vb_cur != pvb_reg);
    assign cls_n = cls_reg + AW'(diff);
    assign more = cls_n < len_reg;
    assign rk_r = AW'(cur_rdata);
    assign r_low = rk_r <= AW'(1);
    assign inb = (ip <= n1) && (jp <= n1);
    assign eq = (txt_rdata == t1_reg);

    always_comb begin
        sts.action = req_reg.action;
        sts.empty = (len_reg == '0);
        sts.req_ok = req_ok;
        sts.at_n = (cnt_reg == nv);
        sts.at_top = (cnt_reg == top);
        sts.at_one = (cnt_reg == VW'(1));
        sts.first = first_reg;
        sts.more = more;
        sts.r_low = r_low;
        sts.inb = inb;
        sts.eq = eq;
        sts.out_free = out_free;
    end

    always_comb begin
        req_next = req_reg;
        res_next = res_reg;
        len_next = len_reg;
        built_next = built_reg;
        cnt_next = cnt_reg;
        e_next = e_reg;
        step_next = step_reg;
        sel_next = sel_reg;
        first_next = first_reg;
        cls_next = cls_reg;
        pos_next = pos_reg;
        key_next = key_reg;
        sum_next = sum_reg;
        va_next = va_reg;
        pva_next = pva_reg;
        pvb_next = pvb_reg;
        a_next = a_reg;
        hi_next = hi_reg;
        r_next = r_reg;
        j_next = j_reg;
        k_next = k_reg;
        t1_next = t1_reg;
        txt_we = 1'b0;
        txt_waddr = '0;
        txt_wdata = '0;
        txt_raddr = '0;
        ord_we = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_raddr = '0;
        lcp_we = 1'b0;
        lcp_waddr = '0;
        lcp_wdata = '0;
        lcp_raddr = '0;
        bkt_we = 1'b0;
        bkt_waddr = '0;
        bkt_wdata = '0;
        bkt_raddr = '0;
        cur_we = 1'b0;
        cur_waddr = '0;
        cur_wdata = '0;
        cur_raddr = '0;
        alt_we = 1'b0;
        alt_waddr = '0;
        alt_wdata = '0;
        alt_raddr = '0;
        mv_next = mv_reg;
        if (m_ready) mv_next = 1'b0;
        case (cmd.phase)
            S_IDLE: begin
                if (s_valid) req_next = s_data;
            end
            S_DEC: begin
                res_next.status = ST_OK;
                res_next.suffix_start = '0;
                res_next.lcp_prev = '0;
                case (req_reg.action)
                    ACT_APPEND: begin
                        if (!ch_ok) begin
                            res_next.status = ST_BAD_CHAR;
                        end else if (len_reg == AW'(MAX_LEN)) begin
                            res_next.status = ST_FULL;
                        end else begin
                            txt_we = 1'b1;
                            txt_waddr = len_reg + AW'(1);
                            txt_wdata = CW'(ch_off) + CW'(1);
                            len_next = len_reg + AW'(1);
                            built_next = 1'b0;
                        end
                    end
                    ACT_BUILD: begin
                        cnt_next = VW'(1);
                        sel_next = 1'b0;
                        first_next = 1'b1;
                    end
                    ACT_READ: begin
                        ord_raddr = AW'(req_reg.rank_index);
                        lcp_raddr = AW'(req_reg.rank_index);
                        if (!req_ok) res_next.status = ST_RANGE;
                    end
                    default: begin
                        len_next = '0;
                        built_next = 1'b0;
                    end
                endcase
                res_next.text_length = FIELD_W'(len_next);
            end
            S_RDW: begin
                res_next.suffix_start = FIELD_W'(ord_rdata);
                res_next.lcp_prev = (req_reg.rank_index == FIELD_W'(1)) ? '0
                                    : FIELD_W'(lcp_rdata);
            end
            S_DONE: begin
                built_next = 1'b1;
                res_next.status = ST_OK;
                res_next.suffix_start = '0;
                res_next.lcp_prev = '0;
                res_next.text_length = FIELD_W'(len_reg);
            end
            S_FIN: begin
                if (out_free) mv_next = 1'b1;
            end
            S_INIT_RD: begin
                txt_raddr = AW'(cnt_reg);
            end
            S_INIT_WR: begin
                cur_we = 1'b1;
                cur_waddr = AW'(cnt_reg);
                cur_wdata = VW'(txt_rdata);
                alt_we = 1'b1;
                alt_waddr = AW'(cnt_reg);
                alt_wdata = cnt_reg;
                cnt_next = sts.at_n ? '0 : cnt_reg + VW'(1);
            end
            S_CLR: begin
                bkt_we = 1'b1;
                bkt_waddr = cnt_reg;
                cnt_next = sts.at_top ? VW'(1) : cnt_reg + VW'(1);
            end
            S_CNT_A, S_PL_A: begin
                alt_raddr = AW'(cnt_reg);
            end
            S_CNT_B, S_PL_B: begin
                pos_next = AW'(alt_rdata);
                cur_raddr = AW'(alt_rdata);
            end
            S_CNT_C, S_PL_C: begin
                key_next = cur_rdata;
                bkt_raddr = cur_rdata;
            end
            S_CNT_D: begin
                bkt_we = 1'b1;
                bkt_waddr = key_reg;
                bkt_wdata = bkt_rdata + VW'(1);
                sum_next = '0;
                cnt_next = sts.at_n ? '0 : cnt_reg + VW'(1);
            end
            S_PFX_RD: begin
                bkt_raddr = cnt_reg;
            end
            S_PFX_WR: begin
                bkt_we = 1'b1;
                bkt_waddr = cnt_reg;
                bkt_wdata = sum_reg + bkt_rdata;
                sum_next = sum_reg + bkt_rdata;
                cnt_next = sts.at_top ? nv : cnt_reg + VW'(1);
            end
            S_PL_D: begin
                ord_we = 1'b1;
                ord_waddr = AW'(bkt_rdata);
                ord_wdata = pos_reg;
                bkt_we = 1'b1;
                bkt_waddr = key_reg;
                bkt_wdata = bkt_rdata - VW'(1);
                if (!sts.at_one) begin
                    cnt_next = cnt_reg - VW'(1);
                end else if (first_reg) begin
                    first_next = 1'b0;
                    step_next = (AW+1)'(1);
                    cnt_next = nv;
                    e_next = AW'(1);
                end else begin
                    sel_next = !sel_reg;
                    cls_next = '0;
                end
            end
            S_TAIL: begin
                alt_we = 1'b1;
                alt_waddr = e_reg;
                alt_wdata = cnt_reg;
                e_next = e_reg + AW'(1);
                cnt_next = sts.at_n ? VW'(1) : cnt_reg + VW'(1);
            end
            S_SH_RD, S_CLS_A, S_INV_RD: begin
                ord_raddr = AW'(cnt_reg);
            end
            S_SH_WR: begin
                if ((AW+1)'(ord_rdata) > step_reg) begin
                    alt_we = 1'b1;
                    alt_waddr = e_reg;
                    alt_wdata = VW'((AW+1)'(ord_rdata) - step_reg);
                    e_next = e_reg + AW'(1);
                end
                cnt_next = sts.at_n ? '0 : cnt_reg + VW'(1);
            end
            S_CLS_B: begin
                a_next = ord_rdata;
                alt_raddr = ord_rdata;
            end
            S_CLS_C: begin
                va_next = alt_rdata;
                hi_next = (hi_sum <= n1);
                alt_raddr = AW'(hi_sum);
            end
            S_CLS_D: begin
                cur_we = 1'b1;
                cur_waddr = a_reg;
                cur_wdata = VW'(cls_n);
                cls_next = cls_n;
                pva_next = va_reg;
                pvb_next = vb_cur;
                if (!sts.at_n) begin
                    cnt_next = cnt_reg + VW'(1);
                end else if (more) begin
                    step_next = st2;
                    cnt_next = VW'(tst2);
                    e_next = AW'(1);
                end else begin
                    cnt_next = VW'(1);
                    sel_next = 1'b0;
                end
            end
            S_INV_WR: begin
                cur_we = 1'b1;
                cur_waddr = ord_rdata;
                cur_wdata = cnt_reg;
                k_next = '0;
                cnt_next = sts.at_n ? VW'(1) : cnt_reg + VW'(1);
            end
            S_K_A: begin
                cur_raddr = AW'(cnt_reg);
            end
            S_K_B: begin
                r_next = rk_r;
                if (r_low) begin
                    lcp_we = 1'b1;
                    lcp_waddr = rk_r;
                    k_next = '0;
                    if (!sts.at_n) cnt_next = cnt_reg + VW'(1);
                end else begin
                    k_next = (k_reg == '0) ? '0 : k_reg - AW'(1);
                    ord_raddr = rk_r - AW'(1);
                end
            end
            S_K_C: begin
                j_next = ord_rdata;
            end
            S_K_D: begin
                if (inb) begin
                    txt_raddr = AW'(ip);
                end else begin
                    lcp_we = 1'b1;
                    lcp_waddr = r_reg;
                    lcp_wdata = k_reg;
                    if (!sts.at_n) cnt_next = cnt_reg + VW'(1);
                end
            end
            S_K_E: begin
                t1_next = txt_rdata;
                txt_raddr = AW'(jp);
            end
            S_K_F: begin
                if (eq) begin
                    k_next = k_reg + AW'(1);
                end else begin
                    lcp_we = 1'b1;
                    lcp_waddr = r_reg;
                    lcp_wdata = k_reg;
                    if (!sts.at_n) cnt_next = cnt_reg + VW'(1);
                end
            end
            default: begin
                mv_next = mv_reg && !m_ready;
            end
        endcase
    end

    always_comb begin
        rk0_we = sel_reg ? alt_we : cur_we;
        rk0_waddr = sel_reg ? alt_waddr : cur_waddr;
        rk0_wdata = sel_reg ? alt_wdata : cur_wdata;
        rk0_raddr = sel_reg ? alt_raddr : cur_raddr;
        rk1_we = sel_reg ? cur_we : alt_we;
        rk1_waddr = sel_reg ? cur_waddr : alt_waddr;
        rk1_wdata = sel_reg ? cur_wdata : alt_wdata;
        rk1_raddr = sel_reg ? cur_raddr : alt_raddr;
        cur_rdata = sel_reg ? rk1_rdata : rk0_rdata;
        alt_rdata = sel_reg ? rk0_rdata : rk1_rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            built_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            built_reg <= built_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
        if (cmd.phase == S_FIN && out_free) mdat_reg <= res_reg;
        cnt_reg <= cnt_next;
        e_reg <= e_next;
        step_reg <= step_next;
        sel_reg <= sel_next;
        first_reg <= first_next;
        cls_reg <= cls_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
        sum_reg <= sum_next;
        va_reg <= va_next;
        pva_reg <= pva_next;
        pvb_reg <= pvb_next;
        a_reg <= a_next;
        hi_reg <= hi_next;
        r_reg <= r_next;
        j_reg <= j_next;
        k_reg <= k_next;
        t1_reg <= t1_next;
    end

    assign m_valid = mv_reg;
    assign m_data = mdat_reg;

    salcp_ram #(.WIDTH(CW), .DEPTH(MAX_LEN + 1)) u_txt (
        .clk(aclk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );

    salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1)) u_ord (
        .clk(aclk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    salcp_ram #(.WIDTH(AW), .DEPTH(MAX_LEN + 1)) u_lcp (
        .clk(aclk), .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata),
        .raddr(lcp_raddr), .rdata(lcp_rdata)
    );

    salcp_ram #(.WIDTH(VW), .DEPTH(KMAX + 1)) u_bkt (
        .clk(aclk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    salcp_ram #(.WIDTH(VW), .DEPTH(MAX_LEN + 1)) u_rk0 (
        .clk(aclk), .we(rk0_we), .waddr(rk0_waddr), .wdata(rk0_wdata),
        .raddr(rk0_raddr), .rdata(rk0_rdata)
    );

    salcp_ram #(.WIDTH(VW), .DEPTH(MAX_LEN + 1)) u_rk1 (
        .clk(aclk), .we(rk1_we), .waddr(rk1_waddr), .wdata(rk1_wdata),
        .raddr(rk1_raddr), .rdata(rk1_rdata)
    );

endmodule
`default_nettype wire

### rtl/salcp_checker.sv
// Port-level checker for the suffix array builder and its bind statement.
`default_nettype none
`include "suffix_array_lcp_builder_macros.svh"
module salcp_checker
    import salcp_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire req_t s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rsp_t m_data
);

    `SALCP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `SALCP_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SALCP_ASSERT_SAME(a_entry_ok, aclk, aresetn, m_valid && (m_data.suffix_start != '0 || m_data.lcp_prev != '0), m_data.status == ST_OK)

endmodule

bind suffix_array_lcp_builder salcp_checker u_salcp_checker (.*);
`default_nettype wire

### sim/suffix_array_lcp_builder_tb.sv
// Testbench for the suffix array builder: directed and random requests checked against a built-in suffix sorter.
`default_nettype none
module suffix_array_lcp_builder_tb;
    import salcp_pkg::*;

    localparam int MAXN = 4096;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    suffix_array_lcp_builder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int quiet = 0;
    int drv_gap = 0;
    int mon_gap = 0;

    // Shadow state of the text and the last built tables.
    int text_len = 0;
    byte unsigned text_codes[MAXN + 2];
    bit built = 0;
    int sa_tab[MAXN + 1];
    int lcp_tab[MAXN + 1];

    function automatic bit suffix_less(int a, int b);
        int k;
        k = 0;
        while (a + k <= text_len && b + k <= text_len) begin
            if (text_codes[a + k] != text_codes[b + k])
                return text_codes[a + k] < text_codes[b + k];
            k++;
        end
        return (a + k > text_len);
    endfunction

    task automatic sort_suffixes();
        int i;
        int j;
        int t;
        int k;
        int rk[MAXN + 1];
        for (i = 1; i <= text_len; i++) begin
            t = i;
            j = i - 1;
            while (j >= 1 && suffix_less(t, sa_tab[j])) begin
                sa_tab[j + 1] = sa_tab[j];
                j--;
            end
            sa_tab[j + 1] = t;
        end
        for (i = 1; i <= text_len; i++)
            rk[sa_tab[i]] = i;
        for (i = 1; i <= text_len; i++) begin
            if (rk[i] == 1) begin
                lcp_tab[1] = 0;
            end else begin
                j = sa_tab[rk[i] - 1];
                k = 0;
                while (i + k <= text_len && j + k <= text_len
                       && text_codes[i + k] == text_codes[j + k])
                    k++;
                lcp_tab[rk[i]] = k;
            end
        end
        built = 1;
    endtask

    task automatic predict_rsp(input req_t r);
        rsp_t e;
        e = '0;
        case (r.action)
            ACT_APPEND: begin
                if (r.char_code < CHAR_BASE || r.char_code >= CHAR_BASE + 8'd26) begin
                    e.status = ST_BAD_CHAR;
                end else if (text_len >= MAXN) begin
                    e.status = ST_FULL;
                end else begin
                    text_len++;
                    text_codes[text_len] = r.char_code - CHAR_BASE + 1;
                    built = 0;
                    e.status = ST_OK;
                end
            end
            ACT_BUILD: begin
                sort_suffixes();
                e.status = ST_OK;
            end
            ACT_READ: begin
                if (!built || r.rank_index < 1 || r.rank_index > text_len) begin
                    e.status = ST_RANGE;
                end else begin
                    e.status = ST_OK;
                    e.suffix_start = sa_tab[r.rank_index];
                    e.lcp_prev = (r.rank_index == 1) ? 0 : lcp_tab[r.rank_index];
                end
            end
            default: begin
                text_len = 0;
                built = 0;
                e.status = ST_OK;
            end
        endcase
        e.text_length = text_len;
        expected_rsps.push_back(e);
    endtask

    function automatic req_t mk_req(act_t a, logic [7:0] c, logic [12:0] idx);
        req_t r;
        r.action = a;
        r.char_code = c;
        r.rank_index = idx;
        return r;
    endfunction

    // Driver.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_rsp(s_data);
                sent++;
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        drv_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, m_data);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_data.status !== e.status)
                        $display("%0t: status exp %0d got %0d", $time, e.status,
                                 m_data.status);
                    if (m_data.suffix_start !== e.suffix_start)
                        $display("%0t: suffix_start exp %0d got %0d", $time,
                                 e.suffix_start, m_data.suffix_start);
                    if (m_data.lcp_prev !== e.lcp_prev)
                        $display("%0t: lcp_prev exp %0d got %0d", $time, e.lcp_prev,
                                 m_data.lcp_prev);
                    if (m_data.text_length !== e.text_length)
                        $display("%0t: text_length exp %0d got %0d", $time,
                                 e.text_length, m_data.text_length);
                    if (m_data !== e)
                        errors++;
                end
            end
            if (mon_gap > 0) begin
                mon_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                mon_gap = $urandom_range(1, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_text(int n, int letters);
        int i;
        for (i = 0; i < n; i++)
            pending_reqs.push_back(mk_req(ACT_APPEND,
                CHAR_BASE + 8'($urandom_range(0, letters - 1)), '0));
    endtask

    task automatic push_reads(int n, int len);
        int i;
        for (i = 0; i < n; i++)
            pending_reqs.push_back(mk_req(ACT_READ, 8'($urandom),
                13'($urandom_range(0, len + 2))));
    endtask

    initial begin
        int i;
        int len;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty build, bad bytes, extremes of each field.
        pending_reqs.push_back(mk_req(ACT_READ, 8'hFF, 13'd1));
        pending_reqs.push_back(mk_req(ACT_BUILD, 8'h00, 13'h1FFF));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h00, '0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'hFF, 13'h1FFF));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h60, '0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h7B, '0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h61, '0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h7A, '0));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h61, '0));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd1));
        pending_reqs.push_back(mk_req(ACT_BUILD, 8'hFF, '0));
        for (i = 0; i <= 4; i++)
            pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'(i)));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'h1FFF));
        pending_reqs.push_back(mk_req(ACT_CLEAR, 8'hAA, 13'h0AAA));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd1));
        pending_reqs.push_back(mk_req(ACT_APPEND, 8'h62, '0));
        pending_reqs.push_back(mk_req(ACT_BUILD, 8'h00, '0));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd1));
        pending_reqs.push_back(mk_req(ACT_CLEAR, 8'h55, 13'h1555));

        // Random sessions: load, build, read; with noise and interrupted loads.
        while (pending_reqs.size() < 1320) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
            push_text(len, $urandom_range(0, 1) ? 2 : 26);
            if ($urandom_range(0, 4) == 0)
                pending_reqs.push_back(mk_req(ACT_APPEND, 8'($urandom), 13'($urandom)));
            pending_reqs.push_back(mk_req(ACT_BUILD, 8'($urandom), 13'($urandom)));
            push_reads($urandom_range(3, 12), len);
            if ($urandom_range(0, 3) == 0) begin
                push_text(2, 3);
                push_reads(2, len);
            end
            pending_reqs.push_back(mk_req(ACT_CLEAR, 8'($urandom), 13'($urandom)));
        end

        // Final session with no idling on either side.
        wait (pending_reqs.size() == 0);
        quiet = 1;
        push_text(24, 3);
        pending_reqs.push_back(mk_req(ACT_BUILD, 8'h00, '0));
        push_reads(36, 24);
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd24));
        pending_reqs.push_back(mk_req(ACT_READ, 8'h00, 13'd25));
        pending_reqs.push_back(mk_req(ACT_CLEAR, 8'h00, '0));

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_rsps.size() == 0);
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests and checked %0d responses over random texts and builds.",
                 sent, got);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #80000000;
        $display("Timeout with %0d responses outstanding.", expected_rsps.size());
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
